// ===== design/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types for the midpoint ellipse rasterizer: operation codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_HOLD    = 4'd0,
        MUL_RX_RX   = 4'd1,
        MUL_RY_RY   = 4'd2,
        MUL_RX2_RY  = 4'd3,
        MUL_RY2_X   = 4'd4,
        MUL_RX2_Y   = 4'd5,
        MUL_TX_TX   = 4'd6,
        MUL_RY2_P   = 4'd7,
        MUL_TY_TY   = 4'd8,
        MUL_RX2_P   = 4'd9,
        MUL_RX2_RY2 = 4'd10
    } t_mul_op;

    // how the previous product is consumed
    typedef enum logic [3:0] {
        ACC_NONE  = 4'd0,
        ACC_RX2   = 4'd1,
        ACC_RY2   = 4'd2,
        ACC_INIT  = 4'd3,
        ACC_R1B   = 4'd4,
        ACC_R1C   = 4'd5,
        ACC_SET   = 4'd6,
        ACC_ADD4  = 4'd7,
        ACC_SUB4  = 4'd8,
        ACC_R2B   = 4'd9,
        ACC_R2C   = 4'd10
    } t_acc_op;

    typedef struct packed {
        logic    load_start;
        logic    step_r1;
        logic    step_r2;
        t_mul_op mul_op;
        t_acc_op acc_op;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic d_pos;    // decision value > 0
        logic r1_exit;  // ry2*x >= rx2*y
        logic y_zero;
    } t_dp_status;

endpackage

// ===== design/midpoint_ellipse_rasterizer_top.sv =====
// Sequencing: a start word runs ST1-ST4, a step word R1A-R1C or R2A-R2C, and the
//   step where region 1 hands over to region 2 adds I1-I6; each then waits in EMIT.
// Flow: one word at a time; a new word is taken only once the last result is
//   loaded, and a held result on the output side stalls that load.
// Reset: synchronous active-low; clears controller state and output valid,
//   region goes idle so step words give nothing until a start.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse point-set generator with two regions and four-way symmetry.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, radius_x, radius_y (low bits first), zero padded
    input  logic [((2*(COORD_BITS-1)+2*RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // right_x, left_x, top_y, bottom_y (low bits first), zero padded
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last_set
    output logic m_axis_tlast
);

    localparam int CB      = COORD_BITS;
    localparam int RB      = RADIUS_BITS;
    localparam int IN_W    = 2 * (CB - 1) + 2 * RB;
    localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 4 * CB;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [CB-1:0] w_rx, w_lx, w_ty, w_by;
    logic [IN_TW-1:0] w_in_data;

    assign w_in_data = s_axis_tdata;

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    mer_dp #(
        .RB (RB),
        .CB (CB)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_center_x (w_in_data[CB-2:0]),
        .i_center_y (w_in_data[2*(CB-1)-1:CB-1]),
        .i_radius_x (w_in_data[2*(CB-1)+RB-1:2*(CB-1)]),
        .i_radius_y (w_in_data[IN_W-1:2*(CB-1)+RB]),
        .o_status   (w_status),
        .o_right_x  (w_rx),
        .o_left_x   (w_lx),
        .o_top_y    (w_ty),
        .o_bottom_y (w_by),
        .o_last_set (m_axis_tlast)
    );

    generate
        if (OUT_TW > OUT_W) begin : g_pad
            assign m_axis_tdata = {{(OUT_TW-OUT_W){1'b0}}, w_by, w_ty, w_lx, w_rx};
        end else begin : g_nopad
            assign m_axis_tdata = {w_by, w_ty, w_lx, w_rx};
        end
    endgenerate

    // a new word only lands in the output register when the slot is free
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over an untaken word");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_start, w_cmd.step_r1, w_cmd.step_r2}))
        else $error("conflicting datapath load commands");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !w_cmd.emit)
        else $error("input accepted while a result is being produced");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_start || w_cmd.step_r1 || w_cmd.step_r2)
            |-> (s_axis_tvalid && s_axis_tready))
        else $error("datapath load without an accepted word");

endmodule

// ===== design/mer_dp.sv =====
// ----------------------------------------------------------------------------
// mer_dp
// Datapath: held center and radii, offsets, decision value, one shared
// multiplier with a registered product, and the output word register.
// ----------------------------------------------------------------------------
module mer_dp
    import mer_pkg::*;
#(
    parameter int RB = 10,
    parameter int CB = 12
) (
    input  logic                 i_clk,
    input  t_dp_cmd              i_cmd,
    input  logic signed [CB-2:0] i_center_x,
    input  logic signed [CB-2:0] i_center_y,
    input  logic        [RB-1:0] i_radius_x,
    input  logic        [RB-1:0] i_radius_y,
    output t_dp_status           o_status,
    output logic        [CB-1:0] o_right_x,
    output logic        [CB-1:0] o_left_x,
    output logic        [CB-1:0] o_top_y,
    output logic        [CB-1:0] o_bottom_y,
    output logic                 o_last_set
);

    localparam int XW  = RB + 1;
    localparam int TW  = RB + 2;
    localparam int AW  = 2 * RB;
    localparam int BW  = 2 * RB + 4;
    localparam int PW  = AW + BW;
    localparam int DW  = PW + 4;
    localparam int SW  = CB + RB + 2;

    logic signed [CB-2:0] r_cx, r_cy;
    logic        [RB-1:0] r_rx, r_ry;
    logic        [AW-1:0] r_rx2, r_ry2;
    logic        [XW-1:0] r_x, r_y;
    logic        [DW-1:0] r_d;
    logic        [PW-1:0] r_prod, r_tmp;
    logic                 r_flag;
    logic        [CB-1:0] r_out_rx, r_out_lx, r_out_ty, r_out_by;
    logic                 r_out_last;

    logic [RB-1:0] rx_sat, ry_sat;
    logic [TW-1:0] tx;
    logic [XW-1:0] ty;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [DW-1:0] prod_ext, rx2_ext, ry2_ext;
    logic [DW-1:0] n_d;
    logic [SW-1:0] cx_ext, cy_ext, x_ext, y_ext;
    logic [SW-1:0] sum_rx, sum_lx, sum_ty, sum_by;

    assign rx_sat = (i_radius_x == '0) ? {{(RB-1){1'b0}}, 1'b1} : i_radius_x;
    assign ry_sat = (i_radius_y == '0) ? {{(RB-1){1'b0}}, 1'b1} : i_radius_y;

    assign tx = {r_x, 1'b1};
    // |y-1|: y = 0 only where region 1 ends on the axis
    assign ty = (r_y == '0) ? {{(XW-1){1'b0}}, 1'b1} : r_y - {{(XW-1){1'b0}}, 1'b1};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_op)
            MUL_RX_RX:   begin mul_a = {{RB{1'b0}}, r_rx};  mul_b = {{(BW-RB){1'b0}}, r_rx}; end
            MUL_RY_RY:   begin mul_a = {{RB{1'b0}}, r_ry};  mul_b = {{(BW-RB){1'b0}}, r_ry}; end
            MUL_RX2_RY:  begin mul_a = r_rx2; mul_b = {{(BW-RB){1'b0}}, r_ry}; end
            MUL_RY2_X:   begin mul_a = r_ry2; mul_b = {{(BW-XW){1'b0}}, r_x}; end
            MUL_RX2_Y:   begin mul_a = r_rx2; mul_b = {{(BW-XW){1'b0}}, r_y}; end
            MUL_TX_TX:   begin mul_a = {{(AW-TW){1'b0}}, tx}; mul_b = {{(BW-TW){1'b0}}, tx}; end
            MUL_RY2_P:   begin mul_a = r_ry2; mul_b = r_prod[BW-1:0]; end
            MUL_TY_TY:   begin mul_a = {{(AW-XW){1'b0}}, ty}; mul_b = {{(BW-XW){1'b0}}, ty}; end
            MUL_RX2_P:   begin mul_a = r_rx2; mul_b = r_prod[BW-1:0]; end
            MUL_RX2_RY2: begin mul_a = r_rx2; mul_b = {{(BW-AW){1'b0}}, r_ry2}; end
            MUL_HOLD:    begin mul_a = '0; mul_b = '0; end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{(DW-PW){1'b0}}, r_prod};
    assign rx2_ext  = {{(DW-AW){1'b0}}, r_rx2};
    assign ry2_ext  = {{(DW-AW){1'b0}}, r_ry2};

    // decision value update, all terms scaled by 4
    always_comb begin
        n_d = r_d;
        unique case (i_cmd.acc_op)
            ACC_INIT: n_d = (ry2_ext << 2) - (prod_ext << 2) + rx2_ext;
            ACC_R1B:  n_d = r_d + (prod_ext << 3) + (ry2_ext << 2);
            ACC_R1C:  n_d = r_flag ? r_d - (prod_ext << 3) : r_d;
            ACC_SET:  n_d = prod_ext;
            ACC_ADD4: n_d = r_d + (prod_ext << 2);
            ACC_SUB4: n_d = r_d - (prod_ext << 2);
            ACC_R2B:  n_d = r_d - (prod_ext << 3) + (rx2_ext << 2);
            ACC_R2C:  n_d = r_flag ? r_d + (prod_ext << 3) : r_d;
            ACC_NONE, ACC_RX2, ACC_RY2: n_d = r_d;
            default:  n_d = r_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_op != MUL_HOLD) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_op == ACC_RX2) begin
            r_rx2 <= r_prod[AW-1:0];
        end
        if (i_cmd.acc_op == ACC_RY2) begin
            r_ry2 <= r_prod[AW-1:0];
        end
        if (i_cmd.acc_op == ACC_R1B) begin
            r_tmp <= r_prod;
        end
        r_d <= n_d;

        if (i_cmd.load_start) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_rx <= rx_sat;
            r_ry <= ry_sat;
            r_x  <= '0;
            r_y  <= {1'b0, ry_sat};
        end else if (i_cmd.step_r1) begin
            r_flag <= o_status.d_pos;
            r_x    <= r_x + {{(XW-1){1'b0}}, 1'b1};
            r_y    <= r_y - {{(XW-1){1'b0}}, o_status.d_pos};
        end else if (i_cmd.step_r2) begin
            r_flag <= !o_status.d_pos;
            r_x    <= r_x + {{(XW-1){1'b0}}, !o_status.d_pos};
            r_y    <= r_y - {{(XW-1){1'b0}}, 1'b1};
        end

        if (i_cmd.emit) begin
            r_out_rx   <= sum_rx[CB-1:0];
            r_out_lx   <= sum_lx[CB-1:0];
            r_out_ty   <= sum_ty[CB-1:0];
            r_out_by   <= sum_by[CB-1:0];
            r_out_last <= o_status.y_zero;
        end
    end

    assign cx_ext = {{(SW-CB+1){r_cx[CB-2]}}, r_cx};
    assign cy_ext = {{(SW-CB+1){r_cy[CB-2]}}, r_cy};
    assign x_ext  = {{(SW-XW){1'b0}}, r_x};
    assign y_ext  = {{(SW-XW){1'b0}}, r_y};
    assign sum_rx = cx_ext + x_ext;
    assign sum_lx = cx_ext - x_ext;
    assign sum_ty = cy_ext + y_ext;
    assign sum_by = cy_ext - y_ext;

    assign o_status.d_pos   = !r_d[DW-1] && (r_d != '0);
    assign o_status.r1_exit = (r_tmp >= r_prod);
    assign o_status.y_zero  = (r_y == '0);

    assign o_right_x  = r_out_rx;
    assign o_left_x   = r_out_lx;
    assign o_top_y    = r_out_ty;
    assign o_bottom_y = r_out_by;
    assign o_last_set = r_out_last;

endmodule

// ===== design/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// Controller: sequences the shared multiplier and the decision updates for
// start, region-1 and region-2 steps, tracks the region, owns output valid.
// ----------------------------------------------------------------------------
module mer_ctrl
    import mer_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_ST1  = 18'h00002,
        S_ST2  = 18'h00004,
        S_ST3  = 18'h00008,
        S_ST4  = 18'h00010,
        S_R1A  = 18'h00020,
        S_R1B  = 18'h00040,
        S_R1C  = 18'h00080,
        S_I1   = 18'h00100,
        S_I2   = 18'h00200,
        S_I3   = 18'h00400,
        S_I4   = 18'h00800,
        S_I5   = 18'h01000,
        S_I6   = 18'h02000,
        S_R2A  = 18'h04000,
        S_R2B  = 18'h08000,
        S_R2C  = 18'h10000,
        S_EMIT = 18'h20000
    } t_state;

    typedef enum logic [1:0] {
        REG_ONE  = 2'b00,
        REG_TWO  = 2'b01,
        REG_DONE = 2'b10
    } t_region;

    t_state  r_state, n_state;
    t_region r_region, n_region;
    logic    r_out_valid, n_out_valid;

    always_comb begin
        n_state           = r_state;
        n_region          = r_region;
        o_in_ready        = 1'b0;
        o_cmd.load_start  = 1'b0;
        o_cmd.step_r1     = 1'b0;
        o_cmd.step_r2     = 1'b0;
        o_cmd.mul_op      = MUL_HOLD;
        o_cmd.acc_op      = ACC_NONE;
        o_cmd.emit        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_START) begin
                        o_cmd.load_start = 1'b1;
                        n_region         = REG_ONE;
                        n_state          = S_ST1;
                    end else if (r_region == REG_ONE) begin
                        o_cmd.step_r1 = 1'b1;
                        n_state       = S_R1A;
                    end else if (r_region == REG_TWO) begin
                        o_cmd.step_r2 = 1'b1;
                        n_state       = S_R2A;
                    end
                end
            end
            S_ST1: begin
                o_cmd.mul_op = MUL_RX_RX;
                n_state      = S_ST2;
            end
            S_ST2: begin
                o_cmd.mul_op = MUL_RY_RY;
                o_cmd.acc_op = ACC_RX2;
                n_state      = S_ST3;
            end
            S_ST3: begin
                o_cmd.mul_op = MUL_RX2_RY;
                o_cmd.acc_op = ACC_RY2;
                n_state      = S_ST4;
            end
            S_ST4: begin
                o_cmd.acc_op = ACC_INIT;
                n_state      = S_EMIT;
            end
            S_R1A: begin
                o_cmd.mul_op = MUL_RY2_X;
                n_state      = S_R1B;
            end
            S_R1B: begin
                o_cmd.mul_op = MUL_RX2_Y;
                o_cmd.acc_op = ACC_R1B;
                n_state      = S_R1C;
            end
            S_R1C: begin
                o_cmd.acc_op = ACC_R1C;
                if (i_status.r1_exit) begin
                    n_region = REG_TWO;
                    n_state  = S_I1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            // region 2 entry: ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2
            S_I1: begin
                o_cmd.mul_op = MUL_TX_TX;
                n_state      = S_I2;
            end
            S_I2: begin
                o_cmd.mul_op = MUL_RY2_P;
                n_state      = S_I3;
            end
            S_I3: begin
                o_cmd.mul_op = MUL_TY_TY;
                o_cmd.acc_op = ACC_SET;
                n_state      = S_I4;
            end
            S_I4: begin
                o_cmd.mul_op = MUL_RX2_P;
                n_state      = S_I5;
            end
            S_I5: begin
                o_cmd.mul_op = MUL_RX2_RY2;
                o_cmd.acc_op = ACC_ADD4;
                n_state      = S_I6;
            end
            S_I6: begin
                o_cmd.acc_op = ACC_SUB4;
                n_state      = S_EMIT;
            end
            S_R2A: begin
                o_cmd.mul_op = MUL_RX2_Y;
                n_state      = S_R2B;
            end
            S_R2B: begin
                o_cmd.mul_op = MUL_RY2_X;
                o_cmd.acc_op = ACC_R2B;
                n_state      = S_R2C;
            end
            S_R2C: begin
                o_cmd.acc_op = ACC_R2C;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.y_zero) begin
                        n_region = REG_DONE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_region    <= REG_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_region    <= n_region;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/midpoint_ellipse_rasterizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top_tb
// Self-checking bench for the midpoint ellipse rasterizer. A scoreboard class
// tracks the arc state (both regions, 4x scaled decision value) for every
// accepted word and checks each point set in order. Directed corner cases
// come first, then random ellipses with random gaps and output stalls.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mer_pkg::*;

    localparam int IN_W        = 48;
    localparam int OUT_W       = 48;
    localparam int ITEM_TARGET = 750;
    localparam int QUIET_FROM  = 660;
    localparam int STALL_LIMIT = 400;

    typedef enum logic [1:0] {
        ARC_UPPER = 2'd0,
        ARC_LOWER = 2'd1,
        ARC_DONE  = 2'd2
    } t_arc_region;

    typedef struct packed {
        logic [11:0] bottom_y;
        logic [11:0] top_y;
        logic [11:0] left_x;
        logic [11:0] right_x;
        logic        last_set;
    } t_point_set;

    class ellipse_scoreboard;
        longint      off_x, off_y, dec;
        longint      hcx, hcy, hrx, hry;
        t_arc_region region;
        t_point_set  sets_q[$];
        int unsigned errors;

        function new();
            off_x  = 0;
            off_y  = 0;
            dec    = 0;
            region = ARC_DONE;
            hcx    = 0;
            hcy    = 0;
            hrx    = 1;
            hry    = 1;
            errors = 0;
        endfunction

        function bit drawing();
            return region != ARC_DONE;
        endfunction

        function void push_set();
            t_point_set p;
            p.right_x  = 12'(hcx + off_x);
            p.left_x   = 12'(hcx - off_x);
            p.top_y    = 12'(hcy + off_y);
            p.bottom_y = 12'(hcy - off_y);
            p.last_set = (off_y == 0);
            sets_q.push_back(p);
        endfunction

        // returns 1 when the word produces a point set
        function bit note_input(logic op, logic signed [10:0] cx, logic signed [10:0] cy,
                                logic [9:0] rx, logic [9:0] ry);
            longint rx2, ry2, tx, ty;
            bit     down, right;
            if (op == OP_START) begin
                hcx    = cx;
                hcy    = cy;
                hrx    = (rx == 0) ? 1 : longint'(rx);
                hry    = (ry == 0) ? 1 : longint'(ry);
                rx2    = hrx * hrx;
                ry2    = hry * hry;
                off_x  = 0;
                off_y  = hry;
                dec    = 4 * ry2 - 4 * rx2 * hry + rx2;
                region = ARC_UPPER;
                push_set();
                return 1'b1;
            end
            if (region == ARC_DONE)
                return 1'b0;
            rx2 = hrx * hrx;
            ry2 = hry * hry;
            if (region == ARC_UPPER) begin
                down  = dec > 0;
                off_x = off_x + 1;
                if (down)
                    off_y = off_y - 1;
                dec = dec + 8 * ry2 * off_x + 4 * ry2;
                if (down)
                    dec = dec - 8 * rx2 * off_y;
                // slope reached -1: restart the decision value for the lower arc
                if (!(ry2 * off_x < rx2 * off_y)) begin
                    tx     = 2 * off_x + 1;
                    ty     = off_y - 1;
                    region = ARC_LOWER;
                    dec    = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
                end
            end else begin
                right = dec <= 0;
                if (right)
                    off_x = off_x + 1;
                dec = dec - 8 * rx2 * (off_y - 1) + 4 * rx2;
                if (right)
                    dec = dec + 8 * ry2 * off_x;
                off_y = off_y - 1;
            end
            push_set();
            if (off_y == 0)
                region = ARC_DONE;
            return 1'b1;
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic last);
            t_point_set  exp_set;
            logic [47:0] exp_word;
            string       names[4];
            names = '{"right_x", "left_x", "top_y", "bottom_y"};
            if (sets_q.size() == 0) begin
                $display("%0t: unexpected word data=%h last=%b", $time, data, last);
                errors++;
                return;
            end
            exp_set  = sets_q.pop_front();
            exp_word = {exp_set.bottom_y, exp_set.top_y, exp_set.left_x, exp_set.right_x};
            for (int i = 0; i < 4; i++) begin
                if (data[i*12 +: 12] !== exp_word[i*12 +: 12]) begin
                    $display("%0t: %s mismatch expected=%0d actual=%0d", $time, names[i],
                             $signed(exp_word[i*12 +: 12]), $signed(data[i*12 +: 12]));
                    errors++;
                end
            end
            if (last !== exp_set.last_set) begin
                $display("%0t: last_set mismatch expected=%b actual=%b", $time,
                         exp_set.last_set, last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;   // center_x, center_y, radius_x, radius_y
    logic             s_axis_tuser = OP_START;  // operation
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // right_x, left_x, top_y, bottom_y
    logic             m_axis_tlast;        // last_set

    ellipse_scoreboard sb;
    int unsigned       set_words = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       stall_left = 0;
    bit                gap_on = 1'b0;
    bit                stall_on = 1'b0;
    bit                quiet = 1'b0;

    midpoint_ellipse_rasterizer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output side: random stall bursts, checks every accepted word
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_on && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic op, logic [10:0] cx, logic [10:0] cy,
                             logic [9:0] rx, logic [9:0] ry);
        if (gap_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, ry, rx, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.note_input(op, cx, cy, rx, ry))
            set_words++;
    endtask

    // start word, then step words until the last set or max_steps
    task automatic draw_ellipse(logic [10:0] cx, logic [10:0] cy, logic [9:0] rx,
                                logic [9:0] ry, int max_steps);
        int n;
        n = 0;
        send_word(OP_START, cx, cy, rx, ry);
        while (sb.drawing() && n < max_steps && set_words < ITEM_TARGET) begin
            send_word(OP_STEP, 11'($urandom), 11'($urandom), 10'($urandom), 10'($urandom));
            n++;
        end
    endtask

    initial begin
        int          kind;
        int          sel;
        int          max_steps;
        logic [9:0]  rx, ry;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_word(OP_STEP, 11'h3ff, 11'h400, 10'h3ff, 10'h3ff);   // step with nothing drawn
        draw_ellipse(11'h400, 11'h3ff, 10'd0, 10'd0, 400);        // zero radii -> 1,1
        send_word(OP_STEP, 11'd0, 11'd0, 10'd0, 10'd0);           // step after last set
        draw_ellipse(11'h3ff, 11'h400, 10'd1023, 10'd1023, 3);
        draw_ellipse(11'd0, 11'd0, 10'd5, 10'd1, 400);            // upper arc reaches y = 0
        draw_ellipse(11'd5, -11'sd7, 10'd1, 10'd6, 400);
        draw_ellipse(11'd100, 11'd200, 10'd1023, 10'd0, 2);       // cut short by a restart
        draw_ellipse(-11'sd3, 11'd4, 10'd3, 10'd2, 400);

        // random ellipses with some noise
        while (set_words < ITEM_TARGET) begin
            gap_on   = $urandom_range(0, 2) != 0;
            stall_on = $urandom_range(0, 2) != 0;
            quiet    = set_words >= QUIET_FROM;
            kind     = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom_range(0, 1)), 11'($urandom), 11'($urandom),
                              10'($urandom), 10'($urandom));
            end else begin
                sel = $urandom_range(0, 19);
                if (sel < 3) begin
                    rx        = 10'($urandom_range(0, 1023));
                    ry        = 10'($urandom_range(0, 1023));
                    max_steps = $urandom_range(1, 20);
                end else if (sel < 6) begin
                    rx        = 10'($urandom_range(0, 60));
                    ry        = 10'($urandom_range(0, 60));
                    max_steps = 400;
                end else begin
                    rx        = 10'($urandom_range(0, 20));
                    ry        = 10'($urandom_range(0, 20));
                    max_steps = 400;
                end
                if ($urandom_range(0, 4) == 0)
                    max_steps = $urandom_range(0, 10);
                draw_ellipse(11'($urandom), 11'($urandom), rx, ry, max_steps);
                if ($urandom_range(0, 5) == 0)
                    send_word(OP_STEP, 11'($urandom), 11'($urandom),
                              10'($urandom), 10'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.sets_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.sets_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
